// ----- rtl/tos_pkg.sv -----
// types and constants shared by the turn sequencer files
`timescale 1ns / 1ps

package tos_pkg;

    localparam int SEQ_W = 63;

    typedef enum logic [2:0] {
        OP_GRAB        = 3'd0,
        OP_RELEASE     = 3'd1,
        OP_CANCEL      = 3'd2,
        OP_SELF_CANCEL = 3'd3,
        OP_INTERRUPT   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        SL_HOLDER      = 3'd0,
        SL_WAIT        = 3'd1,
        SL_CANCELED    = 3'd2,
        SL_INTERRUPTED = 3'd3,
        SL_RELEASED    = 3'd4
    } slot_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_CANCELED = 3'd1,
        ST_RETRY    = 3'd2,
        ST_INTR     = 3'd3,
        ST_RANGE    = 3'd4,
        ST_PARKED   = 3'd5,
        ST_FAULT    = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        WK_GRANTED     = 2'd0,
        WK_CANCELED    = 2'd1,
        WK_INTERRUPTED = 2'd2
    } wake_t;

    typedef enum logic [7:0] {
        FSM_CLEAR   = 8'b0000_0001,
        FSM_IDLE    = 8'b0000_0010,
        FSM_READ    = 8'b0000_0100,
        FSM_WIN     = 8'b0000_1000,
        FSM_EXEC    = 8'b0001_0000,
        FSM_ADV_INC = 8'b0010_0000,
        FSM_ADV_CHK = 8'b0100_0000,
        FSM_DONE    = 8'b1000_0000
    } fsm_t;

    typedef struct packed {
        logic [2:0]       operation;
        logic [SEQ_W-1:0] seqno;
    } in_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [SEQ_W-1:0] turn_now;
        logic             wake_valid;
        logic [SEQ_W-1:0] wake_seqno;
        logic [1:0]       wake_code;
    } out_t;

endpackage

// ----- rtl/tos_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module tos_ram #(
    parameter int WIDTH = 3,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/tos_alu.sv -----
// shared add and compare unit: sum = base + addend, probe compared with sum
`timescale 1ns / 1ps

module tos_alu
    import tos_pkg::*;
#(
    parameter int ADD_W = 5
) (
    input  logic [SEQ_W-1:0] base,
    input  logic [ADD_W-1:0] addend,
    input  logic [SEQ_W-1:0] probe,
    output logic [SEQ_W:0]   sum,
    output logic             lt,
    output logic             eq
);

    // one bit wider than the turn so the window top never wraps
    assign sum = {1'b0, base} + (SEQ_W + 1)'(addend);
    assign lt  = {1'b0, probe} < sum;
    assign eq  = {1'b0, probe} == sum;

endmodule

// ----- rtl/total_order_sequencer.sv -----
// top level of the total-order turn sequencer
`timescale 1ns / 1ps

// total-order turn keeper
//
// requests arrive on the s_ channel (valid/ready, payload in_t: operation and
// seqno); each transaction gives exactly one result transaction on the m_
// channel (payload out_t: status, turn after the request, wake notice).
// cfg_wr_en / cfg_wr_data load the start sequence number straight into the
// turn counter; the slot ring is not touched by that write.
//
// one request is in flight at a time. between one acceptance and the next a
// request goes through slot read, turn compare, window compare, decide and
// result hand-off. a release of the current turn adds turn steps (each an
// increment and a slot check), one step plus one per canceled slot skipped.
// the steps run in series, as they share the ram port and the single
// add/compare unit. the result is registered into m_valid at the hand-off
// step, and it stays in the output register until taken. while a result
// waits the block still accepts and works on the next request; that request
// then holds in its final step until the output register is free.
//
// after reset the slot ring is swept to released, one slot a cycle, with
// s_ready low until every slot is done. RING_DEPTH must be a power of two.

module total_order_sequencer
    import tos_pkg::*;
#(
    parameter int RING_DEPTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [SEQ_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_payload,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_payload
);

    localparam int AW    = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH) + 1;

    // sequencer and working registers
    fsm_t             state_reg, state_next;
    in_t              req_reg, req_next;
    logic [SEQ_W-1:0] turn_reg, turn_next;
    logic             lt_reg, lt_next;      // seqno below turn
    logic             eq_reg, eq_next;      // seqno is the turn
    logic             win_reg, win_next;    // seqno below turn + depth
    slot_t            slot_reg, slot_next;
    status_t          status_reg, status_next;
    logic             wake_valid_reg, wake_valid_next;
    logic [SEQ_W-1:0] wake_seqno_reg, wake_seqno_next;
    wake_t            wake_code_reg, wake_code_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [AW-1:0]    clr_cnt_reg, clr_cnt_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_payload_reg, m_payload_next;

    // slot ram port
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [2:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [2:0]    ram_rdata;

    // shared add and compare unit
    logic [CNT_W-1:0] alu_addend;
    logic [SEQ_W:0]   alu_sum;
    logic             alu_lt;
    logic             alu_eq;

    tos_ram #(
        .WIDTH (3),
        .DEPTH (RING_DEPTH)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    tos_alu #(
        .ADD_W (CNT_W)
    ) u_alu (
        .base   (turn_reg),
        .addend (alu_addend),
        .probe  (req_reg.seqno),
        .sum    (alu_sum),
        .lt     (alu_lt),
        .eq     (alu_eq)
    );

    assign s_ready   = (state_reg == FSM_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_comb begin
        logic gt;
        logic adv;

        state_next      = state_reg;
        req_next        = req_reg;
        turn_next       = turn_reg;
        lt_next         = lt_reg;
        eq_next         = eq_reg;
        win_next        = win_reg;
        slot_next       = slot_reg;
        status_next     = status_reg;
        wake_valid_next = wake_valid_reg;
        wake_seqno_next = wake_seqno_reg;
        wake_code_next  = wake_code_reg;
        step_next       = step_reg;
        clr_cnt_next    = clr_cnt_reg;
        m_valid_next    = m_valid_reg;
        m_payload_next  = m_payload_reg;

        ram_we     = 1'b0;
        ram_waddr  = req_reg.seqno[AW-1:0];
        ram_wdata  = SL_RELEASED;
        ram_re     = 1'b0;
        ram_raddr  = s_payload.seqno[AW-1:0];
        alu_addend = '0;

        gt  = !lt_reg && !eq_reg;
        adv = 1'b0;

        // taken result leaves the output register
        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            FSM_CLEAR: begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = SL_RELEASED;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(RING_DEPTH - 1)) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                if (s_valid) begin
                    req_next        = s_payload;
                    ram_re          = 1'b1;
                    status_next     = ST_OK;
                    wake_valid_next = 1'b0;
                    wake_seqno_next = '0;
                    wake_code_next  = WK_GRANTED;
                    state_next      = FSM_READ;
                end
            end
            FSM_READ: begin
                // compare seqno with the turn
                lt_next    = alu_lt;
                eq_next    = alu_eq;
                slot_next  = slot_t'(ram_rdata);
                state_next = FSM_WIN;
            end
            FSM_WIN: begin
                // compare seqno with the top of the window
                alu_addend = CNT_W'(RING_DEPTH);
                win_next   = alu_lt;
                state_next = FSM_EXEC;
            end
            FSM_EXEC: begin
                case (op_t'(req_reg.operation))
                    OP_GRAB: begin
                        if (lt_reg) begin
                            status_next = ST_CANCELED;
                        end else if (!win_reg) begin
                            status_next = ST_RETRY;
                        end else if (slot_reg == SL_INTERRUPTED) begin
                            ram_we      = 1'b1;
                            ram_wdata   = SL_RELEASED;
                            status_next = ST_INTR;
                        end else if (slot_reg == SL_CANCELED) begin
                            status_next = ST_CANCELED;
                        end else if (slot_reg == SL_RELEASED) begin
                            ram_we = 1'b1;
                            if (eq_reg) begin
                                ram_wdata = SL_HOLDER;
                            end else begin
                                ram_wdata   = SL_WAIT;
                                status_next = ST_PARKED;
                            end
                        end else begin
                            status_next = ST_FAULT;
                        end
                    end
                    OP_RELEASE: begin
                        if (!win_reg) begin
                            status_next = ST_RETRY;
                        end else if (eq_reg) begin
                            adv = 1'b1;
                        end else if (gt) begin
                            status_next = (slot_reg == SL_CANCELED) ? ST_OK : ST_FAULT;
                        end else begin
                            status_next = (slot_reg == SL_RELEASED) ? ST_OK : ST_FAULT;
                        end
                    end
                    OP_CANCEL: begin
                        if (!win_reg) begin
                            status_next = ST_FAULT;
                        end else if (gt || (eq_reg && slot_reg != SL_HOLDER)) begin
                            if (slot_reg == SL_WAIT) begin
                                wake_valid_next = 1'b1;
                                wake_seqno_next = req_reg.seqno;
                                wake_code_next  = WK_CANCELED;
                            end
                            ram_we    = 1'b1;
                            ram_wdata = SL_CANCELED;
                        end else begin
                            status_next = ST_CANCELED;
                        end
                    end
                    OP_SELF_CANCEL: begin
                        if (!win_reg) begin
                            status_next = ST_RETRY;
                        end else if (gt) begin
                            ram_we    = 1'b1;
                            ram_wdata = SL_CANCELED;
                        end else if (eq_reg) begin
                            adv = 1'b1;
                        end
                    end
                    OP_INTERRUPT: begin
                        if (lt_reg) begin
                            status_next = ST_RANGE;
                        end else if (!win_reg) begin
                            status_next = ST_RETRY;
                        end else if (slot_reg == SL_HOLDER || slot_reg == SL_CANCELED) begin
                            status_next = ST_RANGE;
                        end else if (slot_reg == SL_WAIT) begin
                            ram_we          = 1'b1;
                            ram_wdata       = SL_RELEASED;
                            wake_valid_next = 1'b1;
                            wake_seqno_next = req_reg.seqno;
                            wake_code_next  = WK_INTERRUPTED;
                        end else if (slot_reg == SL_RELEASED) begin
                            ram_we    = 1'b1;
                            ram_wdata = SL_INTERRUPTED;
                        end
                    end
                    default: begin
                        status_next = ST_FAULT;
                    end
                endcase

                if (adv) begin
                    // free the releasing slot and start stepping the turn
                    ram_we     = 1'b1;
                    ram_wdata  = SL_RELEASED;
                    step_next  = '0;
                    state_next = FSM_ADV_INC;
                end else begin
                    state_next = FSM_DONE;
                end
            end
            FSM_ADV_INC: begin
                alu_addend = CNT_W'(1);
                turn_next  = alu_sum[SEQ_W-1:0];
                ram_re     = 1'b1;
                ram_raddr  = alu_sum[AW-1:0];
                state_next = FSM_ADV_CHK;
            end
            FSM_ADV_CHK: begin
                ram_waddr = turn_reg[AW-1:0];
                if (slot_t'(ram_rdata) == SL_CANCELED && step_reg < CNT_W'(RING_DEPTH)) begin
                    // skip and free a canceled slot
                    ram_we     = 1'b1;
                    ram_wdata  = SL_RELEASED;
                    step_next  = step_reg + 1'b1;
                    state_next = FSM_ADV_INC;
                end else if (slot_t'(ram_rdata) == SL_WAIT) begin
                    // parked waiter gets the turn
                    ram_we          = 1'b1;
                    ram_wdata       = SL_HOLDER;
                    wake_valid_next = 1'b1;
                    wake_seqno_next = turn_reg;
                    wake_code_next  = WK_GRANTED;
                    state_next      = FSM_DONE;
                end else begin
                    state_next = FSM_DONE;
                end
            end
            FSM_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next              = 1'b1;
                    m_payload_next.status     = status_reg;
                    m_payload_next.turn_now   = turn_reg;
                    m_payload_next.wake_valid = wake_valid_reg;
                    m_payload_next.wake_seqno = wake_seqno_reg;
                    m_payload_next.wake_code  = wake_code_reg;
                    state_next                = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_CLEAR;
            end
        endcase

        // start sequence number loads the turn at once
        if (cfg_wr_en) begin
            turn_next = cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_CLEAR;
            turn_reg    <= '0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            turn_reg    <= turn_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
        req_reg        <= req_next;
        lt_reg         <= lt_next;
        eq_reg         <= eq_next;
        win_reg        <= win_next;
        slot_reg       <= slot_next;
        status_reg     <= status_next;
        wake_valid_reg <= wake_valid_next;
        wake_seqno_reg <= wake_seqno_next;
        wake_code_reg  <= wake_code_next;
        step_reg       <= step_next;
        m_payload_reg  <= m_payload_next;
    end

    // only one request in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while another is in flight");

    // a wake notice only comes with an ok status
    a_wake_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.wake_valid) |-> (m_payload.status == ST_OK))
        else $error("wake notice with non-ok status");

    // wake fields are zero when no waiter is resolved
    a_wake_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_payload.wake_valid) |->
            (m_payload.wake_seqno == '0 && m_payload.wake_code == WK_GRANTED))
        else $error("wake fields not cleared");

    // a granted waiter is the new turn
    a_grant_turn: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_payload.wake_valid && m_payload.wake_code == WK_GRANTED) |->
            (m_payload.wake_seqno == m_payload.turn_now))
        else $error("granted waiter differs from turn");

endmodule

// ----- test/total_order_sequencer_test.sv -----
// self-checking testbench for the total-order turn sequencer
`timescale 1ns / 1ps

// a driver and a monitor run as clocked always blocks. the driver takes
// requests from a backlog queue that the main initial block fills, and it
// works out the expected result of every accepted transaction with its own
// copy of the turn counter and slot ring. the monitor compares every result
// transaction with the oldest expected one, field by field.
module total_order_sequencer_test;
    import tos_pkg::*;

    localparam int RING = 16;
    localparam int IDX_W = $clog2(RING);
    localparam int CLK_NS = 10;
    localparam longint LIMIT_CYCLES = 1_000_000;
    localparam int STALL_CYCLES = 400;
    localparam int BACKLOG_MAX = 3;
    localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

    // operation codes the block does not know
    localparam logic [2:0] OP_BAD_FIRST = 3'd5;
    localparam logic [2:0] OP_BAD_LAST = 3'd7;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [SEQ_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_payload;

    // turn keeper state as the testbench sees it
    logic [SEQ_W-1:0] turn_model = '0;
    slot_t ring_model [RING] = '{default: SL_RELEASED};

    in_t request_backlog [$];
    out_t expected_results [$];

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold = 0;
    logic stall_kick = 1'b0;
    int failures = 0;

    total_order_sequencer #(
        .RING_DEPTH(RING)
    ) DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_payload   (s_payload),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

    initial forever #(CLK_NS / 2) aclk = ~aclk;

    // frees the slot of s, moves the turn on past canceled slots (freeing
    // them) and hands the turn to a waiter parked on the new turn
    function automatic void pass_turn(inout out_t res, input logic [SEQ_W-1:0] s);
        int n;
        ring_model[s[IDX_W-1:0]] = SL_RELEASED;
        turn_model = turn_model + 1'b1;
        for (n = 0; n < RING && ring_model[turn_model[IDX_W-1:0]] == SL_CANCELED; n++) begin
            ring_model[turn_model[IDX_W-1:0]] = SL_RELEASED;
            turn_model = turn_model + 1'b1;
        end
        if (ring_model[turn_model[IDX_W-1:0]] == SL_WAIT) begin
            ring_model[turn_model[IDX_W-1:0]] = SL_HOLDER;
            res.wake_valid = 1'b1;
            res.wake_seqno = turn_model;
            res.wake_code = WK_GRANTED;
        end
    endfunction

    // applies one request to the state copy and gives the result it must produce
    function automatic out_t step_turn_keeper(in_t req);
        out_t res;
        logic [SEQ_W-1:0] s;
        logic [IDX_W-1:0] k;
        slot_t st;
        logic in_win;
        s = req.seqno;
        k = s[IDX_W-1:0];
        st = ring_model[k];
        // window has no wrap at the top of the number space
        in_win = {1'b0, s} < ({1'b0, turn_model} + 64'(RING));
        res = '0;
        res.status = ST_OK;
        case (req.operation)
            OP_GRAB: begin
                if (s < turn_model) begin
                    res.status = ST_CANCELED;
                end else if (!in_win) begin
                    res.status = ST_RETRY;
                end else if (st == SL_INTERRUPTED) begin
                    ring_model[k] = SL_RELEASED;
                    res.status = ST_INTR;
                end else if (st == SL_CANCELED) begin
                    res.status = ST_CANCELED;
                end else if (st == SL_RELEASED) begin
                    if (s == turn_model) begin
                        ring_model[k] = SL_HOLDER;
                    end else begin
                        ring_model[k] = SL_WAIT;
                        res.status = ST_PARKED;
                    end
                end else begin
                    res.status = ST_FAULT;
                end
            end
            OP_RELEASE: begin
                if (!in_win) begin
                    res.status = ST_RETRY;
                end else if (s == turn_model) begin
                    pass_turn(res, s);
                end else if (s > turn_model) begin
                    res.status = (st == SL_CANCELED) ? ST_OK : ST_FAULT;
                end else begin
                    res.status = (st == SL_RELEASED) ? ST_OK : ST_FAULT;
                end
            end
            OP_CANCEL: begin
                if (!in_win) begin
                    res.status = ST_FAULT;
                end else if (s > turn_model || (s == turn_model && st != SL_HOLDER)) begin
                    if (st == SL_WAIT) begin
                        res.wake_valid = 1'b1;
                        res.wake_seqno = s;
                        res.wake_code = WK_CANCELED;
                    end
                    ring_model[k] = SL_CANCELED;
                end else begin
                    res.status = ST_CANCELED;
                end
            end
            OP_SELF_CANCEL: begin
                if (!in_win) begin
                    res.status = ST_RETRY;
                end else if (s > turn_model) begin
                    ring_model[k] = SL_CANCELED;
                end else if (s == turn_model) begin
                    pass_turn(res, s);
                end
            end
            OP_INTERRUPT: begin
                if (s < turn_model) begin
                    res.status = ST_RANGE;
                end else if (!in_win) begin
                    res.status = ST_RETRY;
                end else if (st == SL_HOLDER || st == SL_CANCELED) begin
                    res.status = ST_RANGE;
                end else if (st == SL_WAIT) begin
                    ring_model[k] = SL_RELEASED;
                    res.wake_valid = 1'b1;
                    res.wake_seqno = s;
                    res.wake_code = WK_INTERRUPTED;
                end else if (st == SL_RELEASED) begin
                    ring_model[k] = SL_INTERRUPTED;
                end
            end
            default: begin
                res.status = ST_FAULT;
            end
        endcase
        res.turn_now = turn_model;
        return res;
    endfunction

    function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            failures++;
        end
    endfunction

    // driver: a transaction is taken when valid and ready meet at the edge; only
    // then, or while valid is low, is the next request loaded (or valid dropped for a gap)
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(step_turn_keeper(s_payload));
            if (!s_valid || s_ready) begin
                if (request_backlog.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_payload <= request_backlog.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted here so that the stimulus keeps flowing
    always @(posedge aclk) begin
        if (stall_kick)
            rx_hold <= STALL_CYCLES;
        else if (rx_hold != 0)
            rx_hold <= rx_hold - 1;
    end

    // monitor: checks each result transaction and drives the receiver's ready
    always @(posedge aclk) begin : monitor
        out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected: %0h", m_payload);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 64'(want.status), 64'(m_payload.status));
                    check_field("turn_now", 64'(want.turn_now), 64'(m_payload.turn_now));
                    check_field("wake_valid", 64'(want.wake_valid),
                                64'(m_payload.wake_valid));
                    check_field("wake_seqno", 64'(want.wake_seqno),
                                64'(m_payload.wake_seqno));
                    check_field("wake_code", 64'(want.wake_code), 64'(m_payload.wake_code));
                end
            end
            m_ready <= (rx_hold == 0) && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // queue one request; conditions are looked at on the falling edge so the
    // driver never pops in the same step
    task automatic offer_request(logic [2:0] op, logic [SEQ_W-1:0] seq);
        in_t r;
        r.operation = op;
        r.seqno = seq;
        @(negedge aclk);
        while (request_backlog.size() >= BACKLOG_MAX)
            @(negedge aclk);
        request_backlog.push_back(r);
    endtask

    // nothing queued, nothing in flight, every result back, block ready;
    // then a short pause so the block has settled after its last hand-off
    task automatic wait_drained();
        @(negedge aclk);
        while (request_backlog.size() != 0 || s_valid || expected_results.size() != 0 ||
               !s_ready)
            @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // loads the first turn; only ever done with the block idle
    task automatic load_start_seqno(logic [SEQ_W-1:0] value);
        wait_drained();
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        turn_model = value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly requests around the current turn, as a set of threads taking
    // turns would send; some noise with any seqno or an unknown operation
    task automatic random_requests(int count);
        int pick;
        int w;
        logic [2:0] op;
        logic [SEQ_W-1:0] seq;
        repeat (count) begin
            pick = $urandom_range(99);
            seq = turn_model + SEQ_W'($urandom_range(22)) - SEQ_W'(3);
            w = $urandom_range(99);
            if (w < 38)
                op = OP_GRAB;
            else if (w < 62)
                op = OP_RELEASE;
            else if (w < 74)
                op = OP_CANCEL;
            else if (w < 86)
                op = OP_SELF_CANCEL;
            else
                op = OP_INTERRUPT;
            // releases mostly hit the turn itself so the turn keeps moving
            if ((op == OP_RELEASE || op == OP_SELF_CANCEL) && $urandom_range(1))
                seq = turn_model;
            if (pick < 6) begin
                op = 3'($urandom_range(OP_BAD_LAST, OP_BAD_FIRST));
                seq = SEQ_W'({$urandom, $urandom});
            end else if (pick < 12) begin
                seq = SEQ_W'({$urandom, $urandom});
            end
            offer_request(op, seq);
        end
    endtask

    initial begin : stimulus
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part, turn starting at zero
        load_start_seqno('0);
        offer_request(OP_GRAB, 0);          // turn free: becomes holder
        offer_request(OP_GRAB, 2);          // ahead of turn: parks
        offer_request(OP_GRAB, 0);          // slot already held: fault
        offer_request(OP_CANCEL, 0);        // cancel of holder refused
        offer_request(OP_INTERRUPT, 0);     // interrupt of holder out of range
        offer_request(OP_CANCEL, 1);        // ahead of turn: canceled
        offer_request(OP_RELEASE, 1);       // release ahead on canceled slot
        offer_request(OP_RELEASE, 3);       // release ahead, not canceled: fault
        offer_request(OP_GRAB, 3);
        offer_request(OP_SELF_CANCEL, 3);   // parked waiter cancels itself, no wake
        offer_request(OP_RELEASE, 0);       // skips slot 1, grants turn to 2
        offer_request(OP_SELF_CANCEL, 2);   // acts as release, skips 3
        offer_request(OP_GRAB, 1);          // below turn
        offer_request(OP_RELEASE, 0);       // behind turn on released slot
        offer_request(OP_INTERRUPT, 1);     // behind turn
        offer_request(OP_SELF_CANCEL, 1);   // behind turn: nothing to do
        offer_request(OP_GRAB, 5);
        offer_request(OP_CANCEL, 5);        // wakes the waiter as canceled
        offer_request(OP_GRAB, 6);
        offer_request(OP_INTERRUPT, 6);     // wakes the waiter as interrupted
        offer_request(OP_INTERRUPT, 7);     // released slot marked interrupted
        offer_request(OP_INTERRUPT, 7);     // already interrupted
        offer_request(OP_GRAB, 7);          // grab meets the interrupt
        offer_request(OP_GRAB, 20);         // beyond the window from here on
        offer_request(OP_RELEASE, 20);
        offer_request(OP_CANCEL, 20);
        offer_request(OP_SELF_CANCEL, 20);
        offer_request(OP_INTERRUPT, 20);
        offer_request(OP_BAD_FIRST, SEQ_MAX);

        // near the top of the number space so the turn wraps to zero;
        // sender busy, receiver mostly idle, with one long hold-off
        load_start_seqno(SEQ_MAX - SEQ_W'(5));
        tx_idle_pct = 18;
        rx_idle_pct = 81;
        random_requests(180);
        @(posedge aclk);
        stall_kick <= 1'b1;
        @(posedge aclk);
        stall_kick <= 1'b0;
        random_requests(190);

        // top of the range, roles of the two sides swapped
        load_start_seqno(SEQ_MAX);
        tx_idle_pct = 81;
        rx_idle_pct = 18;
        random_requests(370);

        // any start value, no idling, with one full drain mid-way
        load_start_seqno(SEQ_W'({$urandom, $urandom}));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_requests(180);
        wait_drained();
        random_requests(190);

        wait_drained();
        repeat (40) @(negedge aclk);
        if (failures == 0)
            $display("total_order_sequencer regression: pass");
        else
            $display("total_order_sequencer regression: fail");
        $finish;
    end

    // overall watchdog
    initial begin
        #(LIMIT_CYCLES * CLK_NS);
        $display("total_order_sequencer regression: fail");
        $finish;
    end

endmodule
